// ===== rtl/mrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

  // Ring geometry
  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_DUMP    = 3'd4
  } cmd_code_e;

  // Input beat
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] push_byte;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       available;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic push;
    logic pop;
    logic dump;
    logic clear;
    logic restart;
    logic result;
    logic skip_first;
    logic skip_step;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_needed;
    logic slot_free;
    logic skip_done;
  } dp_status_t;

  // Pointer increment with wrap
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mrd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port RAM, registered read, no reset on contents
module mrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/mrd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: decodes accepted beats and steps the drop-oldest scan
module mrd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         in_cmd_i,
  input  wire mrd_pkg::dp_status_t status_i,
  output mrd_pkg::dp_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE       = 4'b0001,
    S_RESULT     = 4'b0010,
    S_SKIP_START = 4'b0100,
    S_SKIP       = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            mrd_pkg::CMD_PUSH: begin
              cmd_o.push = 1'b1;
              if (status_i.skip_needed) begin
                state_d = S_SKIP_START;
              end
            end
            mrd_pkg::CMD_POP: begin
              cmd_o.pop = 1'b1;
              state_d   = S_RESULT;
            end
            mrd_pkg::CMD_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            mrd_pkg::CMD_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            mrd_pkg::CMD_DUMP: begin
              cmd_o.dump = 1'b1;
              state_d    = S_RESULT;
            end
            default: begin
              // unused codes are dropped
            end
          endcase
        end
      end
      S_RESULT: begin
        if (status_i.slot_free) begin
          cmd_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SKIP_START: begin
        cmd_o.skip_first = 1'b1;
        state_d          = S_SKIP;
      end
      S_SKIP: begin
        cmd_o.skip_step = 1'b1;
        if (status_i.skip_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A colliding push must enter the scan
  a_push_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push && status_i.skip_needed |=> state_q == S_SKIP_START)
    else $error("colliding push did not start the drop scan");

  // The scan only leaves through skip_done
  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SKIP && !status_i.skip_done |=> state_q == S_SKIP)
    else $error("drop scan left early");

endmodule

`default_nettype wire

// ===== rtl/mrd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pointers, byte store, scan pointer and output register
module mrd_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          push_byte_i,
  input  wire mrd_pkg::dp_cmd_t    cmd_i,
  output mrd_pkg::dp_status_t      status_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mrd_pkg::out_item_t       out_data_o
);

  localparam int unsigned PW = mrd_pkg::PTR_W;

  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [PW-1:0] dsp_q, dsp_d;
  logic [PW-1:0] dc_q, dc_d;
  logic [PW-1:0] sp_q, sp_d;
  logic          hit_rd_q, hit_rd_d;
  logic          hit_dump_q, hit_dump_d;
  logic          is_dump_q, is_dump_d;
  logic          empty_q, empty_d;
  logic          out_valid_q, out_valid_d;
  mrd_pkg::out_item_t out_q, out_d;

  logic [PW-1:0] nwp, nsp, commit;
  logic          ram_en, ram_we;
  logic [PW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          slot_free, byte_zero;

  assign nwp       = mrd_pkg::ring_next(wp_q);
  assign nsp       = mrd_pkg::ring_next(sp_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign byte_zero = (ram_rdata == 8'd0);
  // scan stops on a terminator or when the next step reaches the head
  assign commit    = byte_zero ? sp_q : nsp;

  assign status_o.skip_needed = (nwp == rp_q) || (nwp == dsp_q);
  assign status_o.slot_free   = slot_free;
  assign status_o.skip_done   = byte_zero || (nsp == wp_q);

  // RAM port select
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = wp_q;
    unique if (cmd_i.push) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      ram_addr = wp_q;
    end else if (cmd_i.pop) begin
      ram_en   = 1'b1;
      ram_addr = rp_q;
    end else if (cmd_i.dump) begin
      ram_en   = 1'b1;
      ram_addr = dc_q;
    end else if (cmd_i.skip_first) begin
      ram_en   = 1'b1;
      ram_addr = sp_q;
    end else if (cmd_i.skip_step) begin
      ram_en   = !status_o.skip_done;
      ram_addr = nsp;
    end else begin
      ram_en = 1'b0;
    end
  end

  mrd_ram #(
    .WIDTH (8),
    .DEPTH (mrd_pkg::RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (push_byte_i),
    .rdata_o (ram_rdata)
  );

  // Pointer and result update
  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    dsp_d       = dsp_q;
    dc_d        = dc_q;
    sp_d        = sp_q;
    hit_rd_d    = hit_rd_q;
    hit_dump_d  = hit_dump_q;
    is_dump_d   = is_dump_q;
    empty_d     = empty_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.push) begin
      wp_d       = nwp;
      hit_rd_d   = (nwp == rp_q);
      hit_dump_d = (nwp == dsp_q);
      sp_d       = mrd_pkg::ring_next(nwp);
    end
    if (cmd_i.pop) begin
      is_dump_d = 1'b0;
      empty_d   = (rp_q == wp_q);
    end
    if (cmd_i.dump) begin
      is_dump_d = 1'b1;
      empty_d   = (dc_q == wp_q);
    end
    if (cmd_i.clear) begin
      wp_d  = '0;
      rp_d  = '0;
      dsp_d = '0;
      dc_d  = '0;
    end
    if (cmd_i.restart) begin
      dc_d = dsp_q;
    end
    if (cmd_i.result) begin
      out_valid_d     = 1'b1;
      out_d.out_byte  = empty_q ? 8'd0 : ram_rdata;
      out_d.available = !empty_q;
      if (!empty_q) begin
        if (is_dump_q) begin
          dc_d = mrd_pkg::ring_next(dc_q);
        end else begin
          rp_d = mrd_pkg::ring_next(rp_q);
        end
      end
    end
    if (cmd_i.skip_step) begin
      if (status_o.skip_done) begin
        if (hit_rd_q) begin
          rp_d = commit;
        end
        if (hit_dump_q) begin
          dsp_d = commit;
        end
      end else begin
        sp_d = nsp;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      dsp_q       <= '0;
      dc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      dsp_q       <= dsp_d;
      dc_q        <= dc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    sp_q       <= sp_d;
    hit_rd_q   <= hit_rd_d;
    hit_dump_q <= hit_dump_d;
    is_dump_q  <= is_dump_d;
    empty_q    <= empty_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result is loaded only into a free or draining slot
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  // Output valid rises only after a result load
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.result))
    else $error("output valid without a result load");

  // The head moves only on push or clear
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.push && !cmd_i.clear |=> $stable(wp_q))
    else $error("head pointer moved without push or clear");

endmodule

`default_nettype wire

// ===== rtl/message_ring_drop_oldest.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake               Beat
// in       in   in_valid_i/in_ready_o   mrd_pkg::in_item_t  {command, push_byte}
// out      out  out_valid_o/out_ready_i mrd_pkg::out_item_t {out_byte, available}
//
// One command at a time. Clear, restart and a push that does not collide finish
// on acceptance. Pop and dump read run a RAM read, then a result load, which waits
// while the previous result beat sits untaken. A colliding push then runs a scan
// that reads bytes up to the terminator, terminator included, or to the head (single-port RAM).
// Reset is asynchronous, active low, clears the head, tail and dump pointers; RAM contents are kept.
// A stalled output holds its beat; the next command still enters meanwhile.
module message_ring_drop_oldest (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mrd_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mrd_pkg::out_item_t      out_data_o
);

  mrd_pkg::dp_cmd_t    dp_cmd;
  mrd_pkg::dp_status_t dp_status;

  mrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_data_i.command),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  mrd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_byte_i (in_data_i.push_byte),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/msg_ring_monitor.sv =====
`timescale 1ns / 1ps

module msg_ring_monitor
  import mrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        err_count_o,
  output int        open_reads_o
);

  localparam int MAX_REPORTS = 50;

  // Shadow copy of the ring and its four pointers
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] dump_base_ptr;
  logic [PTR_W-1:0] dump_ptr;

  // Bytes that pops and dump reads are owed, oldest first
  out_item_t        owed_reads [$];
  int               err_count;

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Trailing pointer hit by the head: move past the oldest message
  function automatic logic [PTR_W-1:0] drop_message(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = step_ptr(p);
    while (q != head_ptr && ring_mem[q] != 8'h00) q = step_ptr(q);
    return q;
  endfunction

  // Update the shadow ring for one accepted command, queue any owed byte
  function automatic void apply_command(input in_item_t b);
    case (b.command)
      CMD_PUSH: begin
        ring_mem[head_ptr] = b.push_byte;
        head_ptr = step_ptr(head_ptr);
        if (head_ptr == tail_ptr) tail_ptr = drop_message(tail_ptr);
        if (head_ptr == dump_base_ptr) dump_base_ptr = drop_message(dump_base_ptr);
      end
      CMD_POP: begin
        if (tail_ptr == head_ptr) begin
          owed_reads.push_back('{out_byte: 8'h00, available: 1'b0});
        end else begin
          owed_reads.push_back('{out_byte: ring_mem[tail_ptr], available: 1'b1});
          tail_ptr = step_ptr(tail_ptr);
        end
      end
      CMD_CLEAR: begin
        head_ptr      = '0;
        tail_ptr      = '0;
        dump_base_ptr = '0;
        dump_ptr      = '0;
      end
      CMD_RESTART: begin
        dump_ptr = dump_base_ptr;
      end
      CMD_DUMP: begin
        if (dump_ptr == head_ptr) begin
          owed_reads.push_back('{out_byte: 8'h00, available: 1'b0});
        end else begin
          owed_reads.push_back('{out_byte: ring_mem[dump_ptr], available: 1'b1});
          dump_ptr = step_ptr(dump_ptr);
        end
      end
      default: ;  // spare codes do nothing
    endcase
  endfunction

  // Compare result beats first, then account for the command beat
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      head_ptr      = '0;
      tail_ptr      = '0;
      dump_base_ptr = '0;
      dump_ptr      = '0;
      owed_reads.delete();
      err_count     = 0;
      err_count_o  <= 0;
      open_reads_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_reads.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result beat byte=%h avail=%b with no read pending",
                     $time, out_data_i.out_byte, out_data_i.available);
        end else begin
          want = owed_reads.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: out_byte expected %h actual %h",
                       $time, want.out_byte, out_data_i.out_byte);
          end
          if (out_data_i.available !== want.available) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: available expected %b actual %b",
                       $time, want.available, out_data_i.available);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
      err_count_o  <= err_count;
      open_reads_o <= owed_reads.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mrd_pkg::*;

  // First of the three codes the block ignores
  localparam logic [2:0] CMD_SPARE    = 3'(CMD_DUMP) + 3'd1;
  // Idle time after the last result: covers a skip across the whole ring
  localparam int         TAIL_CYCLES  = 4200;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        err_count;
  int        open_reads;
  int        burst_left = 0;
  int        beats_sent = 0;

  message_ring_drop_oldest i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  msg_ring_monitor i_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .err_count_o  (err_count),
    .open_reads_o (open_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  // One command beat; the sender runs in bursts with gaps between them
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] value);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, push_byte: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (cmd <= 3'(CMD_DUMP)) beats_sent++;
  endtask

  // Hold the sender until every owed byte has come back
  task automatic wait_results();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (open_reads != 0) @(posedge clk);
  endtask

  // Nonzero payload bytes, then the terminator
  task automatic push_message(input int max_len);
    repeat ($urandom_range(0, max_len)) send_beat(CMD_PUSH, 8'($urandom_range(1, 255)));
    send_beat(CMD_PUSH, 8'h00);
  endtask

  task automatic dump_session(input int max_reads);
    send_beat(CMD_RESTART, 8'($urandom));
    repeat ($urandom_range(1, max_reads)) send_beat(CMD_DUMP, 8'($urandom));
  endtask

  // Mixed traffic; the ring stays well short of full
  task automatic random_mix(input int n);
    int stop_at;
    int pick;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) push_message(24);
      else if (pick < 65) repeat ($urandom_range(1, 10)) send_beat(CMD_POP, 8'($urandom));
      else if (pick < 85) dump_session(16);
      else if (pick < 95) send_beat(3'($urandom), 8'($urandom));
      else if (pick < 97) send_beat(CMD_CLEAR, 8'($urandom));
      else wait_results();
    end
  endtask

  // Push-heavy traffic so messages pile up, with a few pops and dump sessions
  task automatic flood_messages(input int n);
    int stop_at;
    int pick;
    send_beat(CMD_CLEAR, 8'($urandom));
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 18) push_message(40);
      else if (pick == 18) repeat ($urandom_range(1, 3)) send_beat(CMD_POP, 8'($urandom));
      else dump_session(4);
    end
  endtask

  // Long run with no terminator at all, then read part of it back
  task automatic flood_unterminated(input int n);
    repeat (n) begin
      if ($urandom_range(0, 49) == 0)
        send_beat(($urandom_range(0, 1) == 0) ? CMD_POP : CMD_DUMP, 8'($urandom));
      send_beat(CMD_PUSH, 8'($urandom_range(1, 255)));
    end
    dump_session(20);
    repeat (20) send_beat(CMD_POP, 8'($urandom));
  endtask

  // Receiver: opens with a long hold, then mixes holds, open stretches and jitter
  initial begin
    wait (rst_n);
    repeat (250) @(posedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          out_ready <= 1'b0;
          repeat ($urandom_range(100, 300)) @(posedge clk);
        end
        1, 2, 3: begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 200)) @(posedge clk);
        end
        default: begin
          repeat ($urandom_range(10, 60)) begin
            out_ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring, spare codes, terminators read back raw
    send_beat(CMD_POP, 8'hA5);
    send_beat(CMD_DUMP, 8'h5A);
    send_beat(CMD_SPARE, 8'hFF);
    send_beat(CMD_SPARE + 3'd1, 8'h00);
    send_beat(CMD_SPARE + 3'd2, 8'hFF);
    send_beat(CMD_PUSH, 8'hFF);
    send_beat(CMD_PUSH, 8'h00);
    send_beat(CMD_PUSH, 8'h01);
    send_beat(CMD_PUSH, 8'h80);
    send_beat(CMD_PUSH, 8'h00);
    send_beat(CMD_RESTART, 8'h00);
    send_beat(CMD_DUMP, 8'h00);
    send_beat(CMD_DUMP, 8'h00);
    send_beat(CMD_DUMP, 8'h00);
    send_beat(CMD_POP, 8'h00);
    send_beat(CMD_POP, 8'h00);
    // clear keeps the bytes but resets every pointer
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_POP, 8'h00);
    send_beat(CMD_DUMP, 8'h00);
    send_beat(CMD_PUSH, 8'h7F);
    send_beat(CMD_PUSH, 8'h00);
    send_beat(CMD_DUMP, 8'h00);
    send_beat(CMD_POP, 8'h00);
    wait_results();

    random_mix(450);
    flood_messages(300);
    wait_results();
    random_mix(300);
    flood_unterminated(250);
    random_mix(200);

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && open_reads == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
